@@ sv/spse_pkg.sv @@
// ---------------------------------------------------------------------------
// spse_pkg: shared types and constants of the script push secret extractor
// Push opcode codes, parse phases, result status codes and the event
// structs that pass between the parser and the result queue.
// ---------------------------------------------------------------------------
package spse_pkg;

  // length of the push that carries the secret
  localparam int SECRET_BYTES = 32;
  localparam int WORDS_RAW    = (SECRET_BYTES + 7) / 8;
  localparam int NUM_WORDS    = (WORDS_RAW > 4) ? 4 : WORDS_RAW;
  localparam int WIDX_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SB_AW        = $clog2(SECRET_BYTES);
  localparam int HOLD_CNT_W   = $clog2(NUM_WORDS + 1);

  // push opcodes
  localparam logic [7:0] OP_DIRECT_MIN = 8'h01;
  localparam logic [7:0] OP_DIRECT_MAX = 8'h4b;
  localparam logic [7:0] OP_PUSH_LEN1  = 8'h4c;
  localparam logic [7:0] OP_PUSH_LEN2  = 8'h4d;

  // push counter: the secret is the third push, the counter sticks at three
  localparam logic [1:0] SECRET_PUSH_NUM = 2'd2;
  localparam logic [1:0] PUSH_CNT_SAT    = 2'd3;

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_LEN1,
    PH_LEN2_LO,
    PH_LEN2_HI,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef logic [NUM_WORDS-1:0][63:0] words_t;

  // what one accepted byte produced, plus a look-ahead flag
  typedef struct packed {
    logic    found;
    logic    fail;
    status_t fail_status;
    logic    found_next;
  } parse_evt_t;

  // result queue occupancy
  typedef struct packed {
    logic hold_busy;
    logic fail_pend;
  } q_stat_t;

endpackage

@@ sv/spse_if.sv @@
// ---------------------------------------------------------------------------
// spse channel interfaces
// Valid/ready channels for script bytes in and secret results out.
// ---------------------------------------------------------------------------
interface spse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] script_byte;
  logic       end_of_script;

  modport source (output valid, output script_byte, output end_of_script, input ready);
  modport sink   (input valid, input script_byte, input end_of_script, output ready);
endinterface

interface spse_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] secret_word;
  logic [1:0]  word_index;
  logic [1:0]  status;
  logic        last_of_run;

  modport source (output valid, output secret_word, output word_index, output status,
                  output last_of_run, input ready);
  modport sink   (input valid, input secret_word, input word_index, input status,
                  input last_of_run, output ready);
endinterface

@@ sv/script_push_secret_extractor_top.sv @@
// ---------------------------------------------------------------------------
// script_push_secret_extractor_top: push parser that extracts a secret
// Parses a byte stream of push opcodes and returns the third push as
// 64-bit words when it is exactly the secret length.
// ---------------------------------------------------------------------------
// The block takes one script byte per cycle on in_chan, with end_of_script
// marking the last byte of each script. It follows the push opcodes (direct
// lengths 0x01-0x4b, one-byte and two-byte little-endian length forms, any
// other opcode as an empty push) and, when the third push is exactly the
// secret length, sends the secret on out_chan as four 64-bit words, first
// byte in bits 7:0, word_index 0 to 3, status found, last_of_run on the
// fourth word. A script that ends before that gives one result with status
// not found (ended between pushes) or truncated (ended inside a push).
// Results go through the holding stage and output register; the word burst
// leaves a word per cycle while ready. Input runs at one byte per cycle;
// the parse state is updated by a single pass of logic per byte. The only
// input stalls come from the result holding stage: while a failure result
// waits behind the output register or behind held words, no byte is taken
// until that failure moves into the output register, and a secret that
// completes while an earlier burst is still being held waits for that burst
// to leave. The capture buffer holds no reset value and is only read after
// all its bytes of the current secret have been written.
// ---------------------------------------------------------------------------
module script_push_secret_extractor_top (
  input  logic              clk,
  input  logic              rst_n,
  spse_in_if.sink           in_chan,
  spse_out_if.source        out_chan
);

  logic                 in_fire;
  logic                 q_in_ready;
  spse_pkg::parse_evt_t evt;
  spse_pkg::words_t     words;
  spse_pkg::status_t    out_status;
  spse_pkg::q_stat_t    q_stat;

  // input transfer
  assign in_chan.ready = q_in_ready;
  assign in_fire       = in_chan.valid && q_in_ready;

  // opcode parsing and secret capture
  spse_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_chan.script_byte),
    .in_eos  (in_chan.end_of_script),
    .evt     (evt),
    .words   (words)
  );

  // result holding and output register
  spse_result_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .found_push  (evt.found),
    .words       (words),
    .fail_push   (evt.fail),
    .fail_status (evt.fail_status),
    .found_next  (evt.found_next),
    .in_ready    (q_in_ready),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_word    (out_chan.secret_word),
    .out_idx     (out_chan.word_index),
    .out_status  (out_status),
    .out_last    (out_chan.last_of_run),
    .stat        (q_stat)
  );

  assign out_chan.status = out_status;

  // a new burst never lands on words still waiting to leave
  a_no_burst_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    evt.found |-> !q_stat.hold_busy)
    else $error("secret burst overwrote held words");

  // one byte gives either a secret or a failure, never both
  a_found_xor_fail: assert property (@(posedge clk) disable iff (!rst_n)
    !(evt.found && evt.fail))
    else $error("found and failure on the same byte");

  // a failure is only taken when its slot is free or draining
  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    evt.fail |-> !(q_stat.fail_pend && q_stat.hold_busy))
    else $error("failure result lost behind a pending one");

  // a found run ends on the last word of the secret
  a_found_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.last_of_run && out_status == spse_pkg::ST_FOUND)
      |-> (out_chan.word_index == 2'(spse_pkg::NUM_WORDS - 1)))
    else $error("found run ended on the wrong word");

endmodule

@@ sv/spse_parser.sv @@
// ---------------------------------------------------------------------------
// spse_parser: push opcode parser and secret capture buffer
// Walks the script one byte per transfer, tracks push lengths and counts,
// captures the secret push and assembles its words on the final byte.
// ---------------------------------------------------------------------------
module spse_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          in_byte,
  input  logic                in_eos,
  output spse_pkg::parse_evt_t evt,
  output spse_pkg::words_t    words
);

  spse_pkg::phase_t phase_r, phase_nxt, phase_step;
  logic [15:0] br_r, br_nxt;
  logic [7:0]  llb_r, llb_nxt;
  logic [1:0]  pc_r, pc_nxt;
  logic        cap_r, cap_nxt;
  logic        found_r, found_nxt;

  logic [7:0]  buf_mem [spse_pkg::SECRET_BYTES];
  logic [spse_pkg::SB_AW-1:0] wr_pos;

  logic        last_data;
  logic        found_evt;

  assign last_data = (phase_r == spse_pkg::PH_DATA) && (br_r == 16'd1);
  assign found_evt = in_fire && last_data && cap_r;
  assign wr_pos    = spse_pkg::SB_AW'(16'(spse_pkg::SECRET_BYTES) - br_r);

  // next state
  always_comb begin
    logic        do_begin;
    logic        cnt_push;
    logic [15:0] len;
    phase_nxt  = phase_r;
    br_nxt     = br_r;
    llb_nxt    = llb_r;
    pc_nxt     = pc_r;
    cap_nxt    = cap_r;
    found_nxt  = found_r;
    phase_step = phase_r;
    do_begin   = 1'b0;
    cnt_push   = 1'b0;
    len        = 16'd0;
    if (in_fire) begin
      unique case (phase_r)
        spse_pkg::PH_OPCODE: begin
          if (in_byte >= spse_pkg::OP_DIRECT_MIN && in_byte <= spse_pkg::OP_DIRECT_MAX) begin
            do_begin = 1'b1;
            len      = {8'h00, in_byte};
          end else if (in_byte == spse_pkg::OP_PUSH_LEN1) begin
            phase_nxt = spse_pkg::PH_LEN1;
          end else if (in_byte == spse_pkg::OP_PUSH_LEN2) begin
            phase_nxt = spse_pkg::PH_LEN2_LO;
          end else begin
            cnt_push = 1'b1;   // any other opcode is an empty push
          end
        end
        spse_pkg::PH_LEN1: begin
          do_begin = 1'b1;
          len      = {8'h00, in_byte};
        end
        spse_pkg::PH_LEN2_LO: begin
          llb_nxt   = in_byte;
          phase_nxt = spse_pkg::PH_LEN2_HI;
        end
        spse_pkg::PH_LEN2_HI: begin
          do_begin = 1'b1;
          len      = {in_byte, llb_r};
        end
        spse_pkg::PH_DATA: begin
          br_nxt = br_r - 16'd1;
          if (br_r == 16'd1) begin
            if (cap_r) begin
              cap_nxt   = 1'b0;
              found_nxt = 1'b1;
              phase_nxt = spse_pkg::PH_DONE;
            end else begin
              cnt_push  = 1'b1;
              phase_nxt = spse_pkg::PH_OPCODE;
            end
          end
        end
        spse_pkg::PH_DONE: begin
        end
        default: begin
        end
      endcase

      if (do_begin) begin
        if (len == 16'd0) begin
          cnt_push  = 1'b1;
          phase_nxt = spse_pkg::PH_OPCODE;
        end else begin
          cap_nxt   = (pc_r == spse_pkg::SECRET_PUSH_NUM) &&
                      (len == 16'(spse_pkg::SECRET_BYTES));
          br_nxt    = len;
          phase_nxt = spse_pkg::PH_DATA;
        end
      end

      if (cnt_push && pc_r != spse_pkg::PUSH_CNT_SAT) begin
        pc_nxt = pc_r + 2'd1;
      end

      phase_step = phase_nxt;

      // end marker: back to the start of a new script
      if (in_eos) begin
        phase_nxt = spse_pkg::PH_OPCODE;
        br_nxt    = 16'd0;
        llb_nxt   = 8'd0;
        pc_nxt    = 2'd0;
        cap_nxt   = 1'b0;
        found_nxt = 1'b0;
      end
    end
  end

  // outputs
  always_comb begin
    evt.found       = found_evt;
    evt.fail        = in_fire && in_eos && !found_r && !found_evt;
    evt.fail_status = (phase_step == spse_pkg::PH_OPCODE) ? spse_pkg::ST_NOT_FOUND
                                                          : spse_pkg::ST_TRUNCATED;
    evt.found_next  = last_data && cap_r;
  end

  // secret words: buffered bytes, with the byte now arriving as the last one
  always_comb begin
    for (int k = 0; k < spse_pkg::NUM_WORDS; k++) begin
      for (int b = 0; b < 8; b++) begin
        if (k * 8 + b < spse_pkg::SECRET_BYTES - 1) begin
          words[k][b*8 +: 8] = buf_mem[spse_pkg::SB_AW'(k * 8 + b)];
        end else if (k * 8 + b == spse_pkg::SECRET_BYTES - 1) begin
          words[k][b*8 +: 8] = in_byte;
        end else begin
          words[k][b*8 +: 8] = 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= spse_pkg::PH_OPCODE;
      br_r    <= 16'd0;
      llb_r   <= 8'd0;
      pc_r    <= 2'd0;
      cap_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      br_r    <= br_nxt;
      llb_r   <= llb_nxt;
      pc_r    <= pc_nxt;
      cap_r   <= cap_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && phase_r == spse_pkg::PH_DATA && cap_r) begin
      buf_mem[wr_pos] <= in_byte;
    end
  end

endmodule

@@ sv/spse_result_queue.sv @@
// ---------------------------------------------------------------------------
// spse_result_queue: result holding and output register
// Holds a burst of secret words and one failure result, and feeds them
// in order into the output register.
// ---------------------------------------------------------------------------
module spse_result_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              found_push,
  input  spse_pkg::words_t  words,
  input  logic              fail_push,
  input  spse_pkg::status_t fail_status,
  input  logic              found_next,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_word,
  output logic [1:0]        out_idx,
  output spse_pkg::status_t out_status,
  output logic              out_last,
  output spse_pkg::q_stat_t stat
);

  spse_pkg::words_t                  hold_word_r;
  logic [spse_pkg::HOLD_CNT_W-1:0]   hold_cnt_r, hold_cnt_nxt;
  logic [spse_pkg::WIDX_W-1:0]       hold_idx_r, hold_idx_nxt;
  logic                              fail_pend_r, fail_pend_nxt;
  spse_pkg::status_t                 fail_status_r;

  logic                              out_valid_r, out_valid_nxt;
  logic [63:0]                       out_word_r;
  logic [1:0]                        out_idx_r;
  spse_pkg::status_t                 out_status_r;
  logic                              out_last_r;

  logic out_free, hold_busy, take_hold, take_fail;

  assign hold_busy = (hold_cnt_r != '0);
  assign out_free  = !out_valid_r || out_ready;
  assign take_hold = out_free && hold_busy;
  assign take_fail = out_free && !hold_busy && fail_pend_r;

  // a failure slot that drains this cycle is free again; a new burst waits
  // until the last one has left the holding words
  assign in_ready = (!fail_pend_r || take_fail) && !(hold_busy && found_next);

  always_comb begin
    out_valid_nxt = take_hold || take_fail || (out_valid_r && !out_ready);
    hold_cnt_nxt  = hold_cnt_r;
    hold_idx_nxt  = hold_idx_r;
    fail_pend_nxt = fail_pend_r;
    if (found_push) begin
      hold_cnt_nxt = spse_pkg::HOLD_CNT_W'(spse_pkg::NUM_WORDS);
      hold_idx_nxt = '0;
    end else if (take_hold) begin
      hold_cnt_nxt = hold_cnt_r - spse_pkg::HOLD_CNT_W'(1);
      hold_idx_nxt = hold_idx_r + spse_pkg::WIDX_W'(1);
    end
    if (fail_push) begin
      fail_pend_nxt = 1'b1;
    end else if (take_fail) begin
      fail_pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt_r  <= '0;
      hold_idx_r  <= '0;
      fail_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hold_cnt_r  <= hold_cnt_nxt;
      hold_idx_r  <= hold_idx_nxt;
      fail_pend_r <= fail_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (found_push) begin
      hold_word_r <= words;
    end
    if (fail_push) begin
      fail_status_r <= fail_status;
    end
    if (take_hold) begin
      out_word_r   <= hold_word_r[hold_idx_r];
      out_idx_r    <= 2'(hold_idx_r);
      out_status_r <= spse_pkg::ST_FOUND;
      out_last_r   <= (hold_cnt_r == spse_pkg::HOLD_CNT_W'(1));
    end else if (take_fail) begin
      out_word_r   <= 64'd0;
      out_idx_r    <= 2'd0;
      out_status_r <= fail_status_r;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word       = out_word_r;
  assign out_idx        = out_idx_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;
  assign stat.hold_busy = hold_busy;
  assign stat.fail_pend = fail_pend_r;

endmodule

@@ bench/spse_secret_checker.sv @@
// ---------------------------------------------------------------------------
// spse_secret_checker: result prediction and comparison
// Watches the byte and result channels, runs its own push parser on every
// accepted byte, and compares each accepted result with the oldest
// predicted one.
// ---------------------------------------------------------------------------
module spse_secret_checker (
  input  logic clk,
  input  logic rst_n,
  spse_in_if   in_mon,
  spse_out_if  out_mon,
  output int   n_mismatch,
  output int   n_pending
);

  typedef struct packed {
    logic [63:0]       word;
    logic [1:0]        widx;
    spse_pkg::status_t status;
    logic              last;
  } secret_result_t;

  localparam int SHOW_LIMIT = 10;

  // parser copy
  spse_pkg::phase_t phase;
  logic [15:0] remain;
  logic [7:0]  len_lo;
  logic [1:0]  pushes;
  logic        capt;
  logic        found;
  logic [7:0]  secret_mem [spse_pkg::SECRET_BYTES];

  secret_result_t secret_results_q[$];

  initial begin
    n_mismatch = 0;
    n_pending  = 0;
  end

  task automatic clear_parser();
    phase  = spse_pkg::PH_OPCODE;
    remain = '0;
    len_lo = '0;
    pushes = '0;
    capt   = 1'b0;
    found  = 1'b0;
  endtask

  task automatic bump_push();
    if (pushes < spse_pkg::PUSH_CNT_SAT) pushes = pushes + 2'd1;
  endtask

  // push length known: empty push completes here, otherwise data follows
  task automatic start_push(input logic [15:0] len);
    if (len == 16'd0) begin
      bump_push();
      phase = spse_pkg::PH_OPCODE;
    end else begin
      capt   = (pushes == spse_pkg::SECRET_PUSH_NUM) &&
               (len == 16'(spse_pkg::SECRET_BYTES));
      remain = len;
      phase  = spse_pkg::PH_DATA;
    end
  endtask

  task automatic parse_script_byte(input logic [7:0] sbyte, input logic eos);
    int             k;
    int             bi;
    int             idx;
    logic [63:0]    w;
    secret_result_t r;
    case (phase)
      spse_pkg::PH_OPCODE: begin
        if (sbyte >= spse_pkg::OP_DIRECT_MIN && sbyte <= spse_pkg::OP_DIRECT_MAX)
          start_push({8'h00, sbyte});
        else if (sbyte == spse_pkg::OP_PUSH_LEN1) phase = spse_pkg::PH_LEN1;
        else if (sbyte == spse_pkg::OP_PUSH_LEN2) phase = spse_pkg::PH_LEN2_LO;
        else bump_push();
      end
      spse_pkg::PH_LEN1: start_push({8'h00, sbyte});
      spse_pkg::PH_LEN2_LO: begin
        len_lo = sbyte;
        phase  = spse_pkg::PH_LEN2_HI;
      end
      spse_pkg::PH_LEN2_HI: start_push({sbyte, len_lo});
      spse_pkg::PH_DATA: begin
        if (capt) secret_mem[spse_pkg::SECRET_BYTES - int'(remain)] = sbyte;
        remain = remain - 16'd1;
        if (remain == 16'd0) begin
          if (capt) begin
            capt  = 1'b0;
            found = 1'b1;
            phase = spse_pkg::PH_DONE;
            for (k = 0; k < spse_pkg::NUM_WORDS; k++) begin
              w = '0;
              for (bi = 0; bi < 8; bi++) begin
                idx = k * 8 + bi;
                if (idx < spse_pkg::SECRET_BYTES)
                  w = w | (64'(secret_mem[idx]) << (8 * bi));
              end
              r.word   = w;
              r.widx   = 2'(k);
              r.status = spse_pkg::ST_FOUND;
              r.last   = (k == spse_pkg::NUM_WORDS - 1);
              secret_results_q.push_back(r);
            end
          end else begin
            bump_push();
            phase = spse_pkg::PH_OPCODE;
          end
        end
      end
      default: ;
    endcase
    if (eos) begin
      if (!found) begin
        r.word   = '0;
        r.widx   = '0;
        r.status = (phase == spse_pkg::PH_OPCODE) ? spse_pkg::ST_NOT_FOUND
                                                  : spse_pkg::ST_TRUNCATED;
        r.last   = 1'b1;
        secret_results_q.push_back(r);
      end
      clear_parser();
    end
  endtask

  always @(posedge clk) begin : watch
    secret_result_t want;
    if (!rst_n) begin
      clear_parser();
      secret_results_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        parse_script_byte(in_mon.script_byte, in_mon.end_of_script);
      if (out_mon.valid && out_mon.ready) begin
        if (secret_results_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= SHOW_LIMIT)
            $display("unexpected result: word %h idx %0d status %0d last %0b",
                     out_mon.secret_word, out_mon.word_index, out_mon.status,
                     out_mon.last_of_run);
        end else begin
          want = secret_results_q.pop_front();
          if (out_mon.secret_word !== want.word || out_mon.word_index !== want.widx ||
              out_mon.status !== 2'(want.status) || out_mon.last_of_run !== want.last) begin
            n_mismatch++;
            if (n_mismatch <= SHOW_LIMIT) begin
              $display("result differs: exp word %h idx %0d status %0d last %0b",
                       want.word, want.widx, want.status, want.last);
              $display("                got word %h idx %0d status %0d last %0b",
                       out_mon.secret_word, out_mon.word_index, out_mon.status,
                       out_mon.last_of_run);
            end
          end
        end
      end
    end
    n_pending = secret_results_q.size();
  end

endmodule

@@ bench/script_push_secret_extractor_top_tb.sv @@
// ---------------------------------------------------------------------------
// script_push_secret_extractor_top_tb: bench for the push secret extractor
// Feeds short directed scripts and then random scripts, mostly well-formed
// secret carriers with random content, under three idling patterns and one
// long output hold-off; a separate checker predicts and compares results.
// ---------------------------------------------------------------------------
module script_push_secret_extractor_top_tb;

  localparam int RESET_CYCLES   = 8;
  localparam int HOLD_LEN       = 80;    // long receiver hold-off
  localparam int QUIET_LIMIT    = 1500;  // cycles without any transfer
  localparam int DRAIN_CYCLES   = 20;    // results leave through the holding and output registers
  localparam int ITEMS_PER_PASS = 70;

  logic clk;
  logic rst_n;

  spse_in_if  in_chan ();
  spse_out_if out_chan ();

  int n_mismatch;
  int n_pending;

  // idling knobs, changed by the stimulus between passes
  int src_idle_pct;
  int rcv_idle_pct;
  bit hold_go;
  int hold_cnt;
  int quiet_cnt;
  int bytes_sent;

  logic [7:0] script_q[$];

  script_push_secret_extractor_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  spse_secret_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .n_mismatch (n_mismatch),
    .n_pending  (n_pending)
  );

  // 4 time unit clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver: random back-pressure, or one long hold-off once requested
  // while the sender keeps offering bytes, so the holding stage fills up
  initial hold_cnt = 0;
  always @(negedge clk) begin
    if (hold_go && hold_cnt < HOLD_LEN) begin
      hold_cnt <= hold_cnt + 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // watchdog: count cycles in which nothing moves on either channel
  initial quiet_cnt = 0;
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || !rst_n) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QUIET_LIMIT) begin
      $display("script_push_secret_extractor_top: mismatch");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // offer one byte; optional idle cycles first, then hold until the transfer.
  // returns on the falling edge after the transfer with valid still high, so
  // the next call either keeps it high or drops it, never both in one step
  task automatic send_byte(input logic [7:0] sbyte, input logic eos);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.script_byte   <= sbyte;
    in_chan.end_of_script <= eos;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // whole script from script_q, end marker on its last byte
  task automatic send_script();
    int i;
    for (i = 0; i < script_q.size(); i++)
      send_byte(script_q[i], i == script_q.size() - 1);
  endtask

  // append one push of len data bytes; form picks direct, one-byte or
  // two-byte length. a zero-length direct push is an empty opcode
  task automatic add_push(input int len, input int form);
    int v;
    if (form == 0 && len > int'(spse_pkg::OP_DIRECT_MAX)) form = 1;
    if (form == 0 && len == 0) begin
      v = $urandom_range(256, int'(spse_pkg::OP_PUSH_LEN2) + 1);
      script_q.push_back((v == 256) ? 8'h00 : 8'(v));
    end else begin
      if (form == 0) begin
        script_q.push_back(8'(len));
      end else if (form == 1) begin
        script_q.push_back(spse_pkg::OP_PUSH_LEN1);
        script_q.push_back(8'(len));
      end else begin
        script_q.push_back(spse_pkg::OP_PUSH_LEN2);
        script_q.push_back(8'(len));
        script_q.push_back(8'(len >> 8));
      end
      repeat (len) script_q.push_back(8'($urandom));
    end
  endtask

  // cut the script short at a random point (keeps at least one byte)
  task automatic cut_script();
    int keep;
    if (script_q.size() > 1) begin
      keep = $urandom_range(script_q.size() - 1, 1);
      while (script_q.size() > keep) void'(script_q.pop_back());
    end
  endtask

  task automatic random_script();
    int kind;
    int n_pre;
    int slen;
    script_q.delete();
    kind = $urandom_range(99);
    if (kind < 65) begin
      // secret carrier: usually two pushes, then the secret push (sometimes one byte off in length), then trailing junk
      n_pre = ($urandom_range(7) != 0) ? 2 : $urandom_range(3);
      repeat (n_pre) add_push($urandom_range(4), $urandom_range(2));
      slen = ($urandom_range(9) != 0) ? spse_pkg::SECRET_BYTES
                                      : spse_pkg::SECRET_BYTES - 1 + 2 * $urandom_range(1);
      add_push(slen, $urandom_range(2));
      repeat ($urandom_range(3)) script_q.push_back(8'($urandom));
      if ($urandom_range(9) == 0) cut_script();
    end else if (kind < 85) begin
      // noise
      repeat ($urandom_range(6, 1)) script_q.push_back(8'($urandom));
    end else begin
      // push with a random two-byte length that the script usually does not finish
      repeat ($urandom_range(2)) add_push($urandom_range(3), $urandom_range(2));
      script_q.push_back(spse_pkg::OP_PUSH_LEN2);
      script_q.push_back(8'($urandom));
      script_q.push_back(8'($urandom));
      repeat ($urandom_range(3)) script_q.push_back(8'($urandom));
      cut_script();
    end
    send_script();
  endtask

  task automatic directed_script(input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [7:0] b2, input int len);
    script_q.delete();
    script_q.push_back(b0);
    if (len > 1) script_q.push_back(b1);
    if (len > 2) script_q.push_back(b2);
    send_script();
  endtask

  initial begin
    int pass;
    int target;
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.script_byte   = '0;
    in_chan.end_of_script = 1'b0;
    out_chan.ready        = 1'b0;
    src_idle_pct          = 21;
    rcv_idle_pct          = 62;
    hold_go               = 1'b0;
    bytes_sent            = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // single-byte scripts: empty opcodes end between pushes, length opcodes
    // ending at once are truncated
    directed_script(8'h00, 8'h00, 8'h00, 1);
    directed_script(8'hff, 8'h00, 8'h00, 1);
    directed_script(spse_pkg::OP_DIRECT_MIN, 8'h00, 8'h00, 1);
    directed_script(spse_pkg::OP_DIRECT_MAX, 8'h00, 8'h00, 1);
    directed_script(spse_pkg::OP_PUSH_LEN1, 8'h00, 8'h00, 1);
    directed_script(spse_pkg::OP_PUSH_LEN2, 8'h00, 8'h00, 1);
    // two-byte length missing its high byte, then the longest length
    directed_script(spse_pkg::OP_PUSH_LEN2, 8'hff, 8'h00, 2);
    directed_script(spse_pkg::OP_PUSH_LEN2, 8'hff, 8'hff, 3);
    // zero lengths complete as empty pushes
    directed_script(spse_pkg::OP_PUSH_LEN1, 8'h00, 8'h00, 2);
    directed_script(spse_pkg::OP_PUSH_LEN2, 8'h00, 8'h00, 3);
    // complete direct push then an empty opcode
    directed_script(spse_pkg::OP_DIRECT_MIN, 8'haa, spse_pkg::OP_PUSH_LEN2 + 8'd1, 3);
    // data bytes missing after a one-byte length
    directed_script(spse_pkg::OP_PUSH_LEN1, 8'hff, 8'h12, 3);

    // three passes: sender idles less, then more, then neither idles; the
    // last pass starts with the long receiver hold-off
    for (pass = 0; pass < 3; pass++) begin
      if (pass == 1) begin
        src_idle_pct = 62;
        rcv_idle_pct = 21;
      end else if (pass == 2) begin
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_go      = 1'b1;
      end
      target = bytes_sent + ITEMS_PER_PASS;
      while (bytes_sent < target) random_script();
    end
    in_chan.valid <= 1'b0;

    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_mismatch == 0 && n_pending == 0) begin
      $display("script_push_secret_extractor_top: match");
    end else begin
      $display("script_push_secret_extractor_top: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/spse_pkg.sv
sv/spse_if.sv
sv/spse_parser.sv
sv/spse_result_queue.sv
sv/script_push_secret_extractor_top.sv
bench/spse_secret_checker.sv
bench/script_push_secret_extractor_top_tb.sv
